// ===== sv/pfcf_pkg.sv =====
// pfcf_pkg: shared types, constants and helpers of the printf conversion formatter
// used by the channel interfaces, the controller, the datapath and the top level

package pfcf_pkg;

  // payload widths
  localparam int BYTE_W  = 8;
  localparam int ARG_W   = 64;
  localparam int COUNT_W = 31;

  // pointer conversion keeps this many low argument bits
  localparam int ARG_BITS = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // decimal conversion: 32-bit binary, 10 bcd digits
  localparam int BIN_W      = 32;
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int DD_W       = BCD_W + BIN_W;
  localparam int DD_CNT_W   = $clog2(BIN_W);

  // digit shift register and its digit count
  localparam int HEX32_DIG = BIN_W / 4;
  localparam int PTR_DIG   = (ARG_BITS + 3) / 4;
  localparam int PTR_SHIFT = ARG_W - 4 * PTR_DIG;
  localparam int DCNT_W    = $clog2(ARG_W / 4 + 1);
  localparam logic [ARG_W-1:0] PTR_MASK = {ARG_W{1'b1}} >> (ARG_W - ARG_BITS);

  // prefix register: up to five bytes
  localparam int PRE_BYTES = 5;
  localparam int PRE_W     = 8 * PRE_BYTES;
  localparam int PCNT_W    = $clog2(PRE_BYTES + 1);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = "%";
  localparam logic [7:0] CH_C     = "c";
  localparam logic [7:0] CH_D     = "d";
  localparam logic [7:0] CH_I     = "i";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_XL    = "x";
  localparam logic [7:0] CH_XU    = "X";
  localparam logic [7:0] CH_P     = "p";
  localparam logic [7:0] CH_S     = "s";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_A_LO  = "a";
  localparam logic [7:0] CH_A_UP  = "A";

  localparam logic [PRE_W-1:0] NIL_TEXT   = "(nil)";
  localparam logic [15:0]      PTR_PREFIX = "0x";

  // what a latched format byte asks for
  typedef enum logic [2:0] {
    K_NONE,
    K_LIT,
    K_CHR,
    K_SDEC,
    K_UDEC,
    K_HEXL,
    K_HEXU,
    K_PTR
  } kind_t;

  // datapath commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_DABBLE,
    OP_DLOAD,
    OP_SHIFT,
    OP_EMIT
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    kind_t kind;
    logic  dd_last;
    logic  skip_ok;
    logic  out_free;
    logic  em_last;
  } dp_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + {4'b0, nib};
    end else begin
      hex_char = base + {4'b0, nib} - 8'd10;
    end
  endfunction

endpackage

// ===== sv/pfcf_if.sv =====
// pfcf_if: valid/ready channel interfaces for format requests and output bytes
// depends on pfcf_pkg for payload widths

interface pfcf_in_if;
  import pfcf_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   fmt_byte;
  logic [ARG_W-1:0]    arg_value;
  logic                string_start;

  modport source (output valid, output fmt_byte, output arg_value, output string_start,
                  input ready);
  modport sink   (input valid, input fmt_byte, input arg_value, input string_start,
                  output ready);
endinterface

interface pfcf_out_if;
  import pfcf_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;
  logic [COUNT_W-1:0]  bytes_written;

  modport source (output valid, output out_byte, output out_last, output bytes_written,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input bytes_written,
                  output ready);
endinterface

// ===== sv/pfcf_ctrl.sv =====
// pfcf_ctrl: sequencing state machine of the formatter
// depends on pfcf_pkg for the command and status types

module pfcf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfcf_pkg::dp_status_t st,
  output pfcf_pkg::dp_op_t     op
);
  import pfcf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DABBLE,
    S_DLOAD,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  always_comb begin
    op        = OP_NONE;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          op        = OP_LOAD;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (st.kind == K_NONE) begin
          state_nxt = S_IDLE;
        end else begin
          op        = OP_SETUP;
          state_nxt = (st.kind == K_SDEC || st.kind == K_UDEC) ? S_DABBLE : S_SKIP;
        end
      end
      S_DABBLE: begin
        op = OP_DABBLE;
        if (st.dd_last) begin
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        op        = OP_DLOAD;
        state_nxt = S_SKIP;
      end
      S_SKIP: begin
        if (st.skip_ok) begin
          op = OP_SHIFT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          op = OP_EMIT;
          if (st.em_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== sv/pfcf_dp.sv =====
// pfcf_dp: datapath of the formatter: byte decode, double-dabble, digit and
// prefix shifters, byte counter and output register; depends on pfcf_pkg

module pfcf_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfcf_pkg::dp_op_t              op,
  output pfcf_pkg::dp_status_t          st,
  input  logic [pfcf_pkg::BYTE_W-1:0]   in_fmt_byte,
  input  logic [pfcf_pkg::ARG_W-1:0]    in_arg_value,
  input  logic                          in_string_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfcf_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last,
  output logic [pfcf_pkg::COUNT_W-1:0]  out_bytes_written
);
  import pfcf_pkg::*;

  // latched request
  logic [BYTE_W-1:0]  byte_r;
  logic [ARG_W-1:0]   arg_r;
  kind_t              kind_r;

  // string state
  logic               pending_r;
  logic [COUNT_W-1:0] count_r;

  // conversion registers
  logic [DD_W-1:0]     dd_r;
  logic [DD_CNT_W-1:0] dd_cnt_r;
  logic [ARG_W-1:0]    dg_r;
  logic [DCNT_W-1:0]   dcnt_r;
  logic [PRE_W-1:0]    pre_r;
  logic [PCNT_W-1:0]   pcnt_r;
  logic                upper_r;

  // output register
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;
  logic [COUNT_W-1:0] out_cnt_r;

  logic               pend_eff;
  logic               pend_in;
  kind_t              kind_in;
  logic [BIN_W-1:0]   w_lo;
  logic [BIN_W-1:0]   w_mag;
  logic [ARG_W-1:0]   ptr_val;
  logic [DD_W-1:0]    dd_adj;
  logic [COUNT_W-1:0] count_inc;
  logic [BYTE_W-1:0]  emit_byte;
  logic               em_last;

  // classify the incoming byte against the pending percent
  assign pend_eff = pending_r & ~in_string_start;

  always_comb begin
    kind_in = K_NONE;
    pend_in = 1'b0;
    if (in_fmt_byte == CH_NUL) begin
      kind_in = K_NONE;
    end else if (!pend_eff) begin
      if (in_fmt_byte == CH_PCT) begin
        pend_in = 1'b1;
      end else begin
        kind_in = K_LIT;
      end
    end else begin
      unique case (in_fmt_byte) inside
        CH_C:       kind_in = K_CHR;
        CH_D, CH_I: kind_in = K_SDEC;
        CH_U:       kind_in = K_UDEC;
        CH_XL:      kind_in = K_HEXL;
        CH_XU:      kind_in = K_HEXU;
        CH_P:       kind_in = K_PTR;
        CH_S:       kind_in = K_NONE;
        default:    kind_in = K_LIT;
      endcase
    end
  end

  assign w_lo    = arg_r[BIN_W-1:0];
  assign w_mag   = w_lo[BIN_W-1] ? (~w_lo + 32'd1) : w_lo;
  assign ptr_val = arg_r & PTR_MASK;

  // one double-dabble step: add 3 to every bcd digit of 5 or more
  always_comb begin
    dd_adj = dd_r;
    for (int k = 0; k < DEC_DIGITS; k++) begin
      if (dd_r[BIN_W+4*k +: 4] >= 4'd5) begin
        dd_adj[BIN_W+4*k +: 4] = dd_r[BIN_W+4*k +: 4] + 4'd3;
      end
    end
  end

  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign emit_byte = (pcnt_r != '0) ? pre_r[PRE_W-1 -: 8]
                                    : hex_char(dg_r[ARG_W-1 -: 4], upper_r);
  assign em_last   = (pcnt_r == PCNT_W'(1) && dcnt_r == '0) ||
                     (pcnt_r == '0 && dcnt_r == DCNT_W'(1));

  always_comb begin
    st.kind     = kind_r;
    st.dd_last  = (dd_cnt_r == DD_CNT_W'(BIN_W - 1));
    st.skip_ok  = (dcnt_r > DCNT_W'(1)) && (dg_r[ARG_W-1 -: 4] == 4'd0);
    st.out_free = !out_valid_r || out_ready;
    st.em_last  = em_last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dd_cnt_r    <= '0;
    end else begin
      if (op == OP_LOAD) begin
        pending_r <= pend_in;
        if (in_string_start) begin
          count_r <= '0;
        end
      end
      if (op == OP_SETUP) begin
        dd_cnt_r <= '0;
      end else if (op == OP_DABBLE) begin
        dd_cnt_r <= dd_cnt_r + 1'b1;
      end
      if (op == OP_EMIT) begin
        count_r     <= count_inc;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        byte_r <= in_fmt_byte;
        arg_r  <= in_arg_value;
        kind_r <= kind_in;
      end
      OP_SETUP: begin
        upper_r <= (kind_r == K_HEXU);
        case (kind_r)
          K_LIT: begin
            pre_r  <= {byte_r, {(PRE_W-8){1'b0}}};
            pcnt_r <= PCNT_W'(1);
            dcnt_r <= '0;
          end
          K_CHR: begin
            pre_r  <= {arg_r[7:0], {(PRE_W-8){1'b0}}};
            pcnt_r <= PCNT_W'(1);
            dcnt_r <= '0;
          end
          K_SDEC: begin
            pre_r  <= {CH_MINUS, {(PRE_W-8){1'b0}}};
            pcnt_r <= {{(PCNT_W-1){1'b0}}, w_lo[BIN_W-1]};
            dcnt_r <= '0;
            dd_r   <= {{BCD_W{1'b0}}, w_mag};
          end
          K_UDEC: begin
            pcnt_r <= '0;
            dcnt_r <= '0;
            dd_r   <= {{BCD_W{1'b0}}, w_lo};
          end
          K_HEXL, K_HEXU: begin
            pcnt_r <= '0;
            dg_r   <= {w_lo, {(ARG_W-BIN_W){1'b0}}};
            dcnt_r <= DCNT_W'(HEX32_DIG);
          end
          K_PTR: begin
            if (ptr_val == '0) begin
              pre_r  <= NIL_TEXT;
              pcnt_r <= PCNT_W'(PRE_BYTES);
              dcnt_r <= '0;
            end else begin
              pre_r  <= {PTR_PREFIX, {(PRE_W-16){1'b0}}};
              pcnt_r <= PCNT_W'(2);
              dg_r   <= ptr_val << PTR_SHIFT;
              dcnt_r <= DCNT_W'(PTR_DIG);
            end
          end
          default: begin
            pcnt_r <= '0;
            dcnt_r <= '0;
          end
        endcase
      end
      OP_DABBLE: begin
        dd_r <= {dd_adj[DD_W-2:0], 1'b0};
      end
      OP_DLOAD: begin
        dg_r   <= {dd_r[DD_W-1 -: BCD_W], {(ARG_W-BCD_W){1'b0}}};
        dcnt_r <= DCNT_W'(DEC_DIGITS);
      end
      OP_SHIFT: begin
        dg_r   <= dg_r << 4;
        dcnt_r <= dcnt_r - 1'b1;
      end
      OP_EMIT: begin
        out_byte_r <= emit_byte;
        out_last_r <= em_last;
        out_cnt_r  <= count_inc;
        if (pcnt_r != '0) begin
          pre_r  <= pre_r << 8;
          pcnt_r <= pcnt_r - 1'b1;
        end else begin
          dg_r   <= dg_r << 4;
          dcnt_r <= dcnt_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last          = out_last_r;
  assign out_bytes_written = out_cnt_r;

endmodule

// ===== sv/printf_conversion_formatter_unit.sv =====
// printf_conversion_formatter_unit: top level of the integer printf formatter
// depends on pfcf_pkg, pfcf_if, pfcf_ctrl and pfcf_dp
//
// usage
//   in_chan takes one format byte per request, with its argument and a
//   string_start flag that opens a new string (clears a pending percent and
//   the byte count). out_chan gives the emitted ascii bytes, 0 to 18 per
//   request, with out_last on the final byte of a request and the running,
//   saturating byte count of the string.
//   one request is worked on at a time; in_chan.ready rises again once the
//   last byte is loaded, or right after decode when the request owes none.
//   a decimal request (%d %i %u) first runs the double-dabble conversion;
//   hex and decimal digits then skip their leading zeros before emission
//   reset (synchronous, active low) clears the pending percent, the byte
//   count and the output register, and leaves the block ready
//   a stalled receiver holds the byte in the output register; the sequencer
//   waits with the next byte, and a new request may be taken while the last
//   byte of the previous one is still waiting

module printf_conversion_formatter_unit (
  input logic        clk,
  input logic        rst_n,
  pfcf_in_if.sink    in_chan,
  pfcf_out_if.source out_chan
);
  import pfcf_pkg::*;

  dp_op_t     op;
  dp_status_t st;

  // sequencer: walks decode, conversion and byte emission
  pfcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .st       (st),
    .op       (op)
  );

  // datapath: decode, double-dabble, shifters, counter and output register
  pfcf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .st                (st),
    .in_fmt_byte       (in_chan.fmt_byte),
    .in_arg_value      (in_chan.arg_value),
    .in_string_start   (in_chan.string_start),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_byte          (out_chan.out_byte),
    .out_last          (out_chan.out_last),
    .out_bytes_written (out_chan.bytes_written)
  );

  // a request is only loaded on an accepted handshake
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_LOAD |-> in_chan.valid && in_chan.ready)
    else $error("load without accepted request");

  // one request at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while busy");

  // a byte is only written into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_EMIT |-> st.out_free)
    else $error("output register overwritten");

  // every delivered byte has been counted
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.bytes_written != '0)
    else $error("byte delivered with zero count");

endmodule

// ===== test/printf_conversion_formatter_unit_tb.sv =====
`timescale 1ns / 1ps
// printf_conversion_formatter_unit_tb: self-checking bench for the integer printf formatter
// depends on pfcf_pkg, pfcf_if and printf_conversion_formatter_unit

module printf_conversion_formatter_unit_tb;
  import pfcf_pkg::*;

  // one emitted character as the output channel should present it
  typedef struct packed {
    logic [BYTE_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } out_char_t;

  // conversion selectors the block knows, plus one letter it does not
  localparam logic [7:0] CONV_SEL [9] = '{CH_C, CH_D, CH_I, CH_U, CH_XL, CH_XU, CH_P, CH_PCT,
                                          CH_S};
  localparam logic [7:0] SEL_UNKNOWN = "q";

  localparam int MAX_MISMATCH_SHOWN = 10;
  localparam int DRAIN_CYCLES       = 100;
  localparam int HOLD_OFF_CYCLES    = 400;

  logic clk;
  logic rst_n;

  pfcf_in_if  in_chan ();
  pfcf_out_if out_chan ();

  printf_conversion_formatter_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // characters still owed by the block, oldest first
  out_char_t pending_chars[$];

  // shadow of the formatter state
  logic               pct_held;
  logic [COUNT_W-1:0] char_count;

  // idling controls shared by the sender, the receiver and the tests
  logic sender_idle;
  logic receiver_idle;
  int   hold_left;
  int   stall_left;
  int   mismatch_count;

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // far beyond the slowest legal run: every request a full 18-byte pointer,
  // every byte waiting out the longest receiver stall
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // expected output: shadow formatter
  // ---------------------------------------------------------------------------

  // one emitted character; the count saturates at its top value
  function automatic void push_char(input logic [7:0] ch);
    out_char_t c;
    if (char_count != COUNT_MAX) begin
      char_count = char_count + 1'b1;
    end
    c.ch    = ch;
    c.last  = 1'b0;
    c.count = char_count;
    pending_chars.push_back(c);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return (upper ? CH_A_UP : CH_A_LO) + {4'b0, d} - 8'd10;
  endfunction

  // decimal digits, most significant first, no leading zeros
  function automatic void push_decimal(input logic [31:0] v);
    logic [7:0] dig [10];
    int k;
    int j;
    k = 0;
    do begin
      dig[k] = digit_char(4'(v % 10), 1'b0);
      v      = v / 10;
      k++;
    end while (v != 0);
    for (j = k - 1; j >= 0; j--) begin
      push_char(dig[j]);
    end
  endfunction

  // hex digits, most significant first, no leading zeros
  function automatic void push_hex(input logic [63:0] v, input logic upper);
    logic [7:0] dig [16];
    int k;
    int j;
    k = 0;
    do begin
      dig[k] = digit_char(v[3:0], upper);
      v      = v >> 4;
      k++;
    end while (v != 0);
    for (j = k - 1; j >= 0; j--) begin
      push_char(dig[j]);
    end
  endfunction

  // works out every character one accepted request owes
  function automatic void render_request(input logic [7:0] fb, input logic [63:0] arg,
                                         input logic start);
    logic [31:0] w;
    logic [63:0] ptr;
    int          first;
    int          i;
    if (start) begin
      pct_held   = 1'b0;
      char_count = '0;
    end
    first = pending_chars.size();
    // zero byte ends the string: nothing out, pending percent dropped, count kept
    if (fb == CH_NUL) begin
      pct_held = 1'b0;
      return;
    end
    if (!pct_held) begin
      if (fb == CH_PCT) begin
        pct_held = 1'b1;
      end else begin
        push_char(fb);
      end
    end else begin
      pct_held = 1'b0;
      w        = arg[31:0];
      ptr      = arg & PTR_MASK;
      case (fb)
        CH_C: push_char(arg[7:0]);
        CH_D, CH_I: begin
          // most negative int negates to itself and prints unsigned in full
          if (w[31]) begin
            push_char(CH_MINUS);
            w = -w;
          end
          push_decimal(w);
        end
        CH_U:  push_decimal(w);
        CH_XL: push_hex({32'b0, w}, 1'b0);
        CH_XU: push_hex({32'b0, w}, 1'b1);
        CH_P: begin
          if (ptr == '0) begin
            for (i = 0; i < 5; i++) begin
              push_char(NIL_TEXT[PRE_W-1-8*i -: 8]);
            end
          end else begin
            push_char(PTR_PREFIX[15:8]);
            push_char(PTR_PREFIX[7:0]);
            push_hex(ptr, 1'b0);
          end
        end
        CH_PCT: push_char(CH_PCT);
        CH_S: ;  // string conversion unsupported: the pair is swallowed
        // unknown selector: percent dropped, the letter goes out as a literal
        default: push_char(fb);
      endcase
    end
    if (pending_chars.size() > first) begin
      pending_chars[pending_chars.size()-1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request sender
  // ---------------------------------------------------------------------------

  // offers one request, with an optional idle burst in front, and returns at
  // the edge where it is taken; valid stays high for a back-to-back follower
  task automatic send_request(input logic [7:0] fb, input logic [63:0] arg,
                              input logic start);
    int gap;
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_chan.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid        = 1'b1;
    in_chan.fmt_byte     = fb;
    in_chan.arg_value    = arg;
    in_chan.string_start = start;
    do @(posedge clk); while (!in_chan.ready);
    render_request(fb, arg, start);
  endtask

  // percent request with a junk argument, then the selector with the real one
  task automatic send_conversion(input logic [7:0] sel, input logic [63:0] arg);
    send_request(CH_PCT, {$urandom, $urandom}, 1'b0);
    send_request(sel, arg, 1'b0);
  endtask

  // argument mix: zero, small, full random, sign bit set, all ones, one-hot,
  // small low half under a random upper half, upper half clear
  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return 64'($urandom_range(0, 20));
      2:       return {$urandom, $urandom};
      3:       return {$urandom, 1'b1, 31'($urandom)};
      4:       return '1;
      5:       return 64'd1 << $urandom_range(0, 63);
      6:       return {$urandom, 32'($urandom_range(0, 99999))};
      default: return {32'd0, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rand_literal();
    logic [7:0] lit;
    if ($urandom_range(0, 7) == 0) begin
      lit = 8'($urandom_range(1, 255));
    end else begin
      lit = 8'($urandom_range(8'h20, 8'h7e));
      if (lit == CH_PCT) begin
        lit = CH_A_UP;
      end
    end
    return lit;
  endfunction

  // ---------------------------------------------------------------------------
  // output receiver: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_chan.ready = 1'b0;
      stall_left--;
    end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
      out_chan.ready = 1'b0;
      stall_left     = $urandom_range(1, 12) - 1;
    end else begin
      out_chan.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_char_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_MISMATCH_SHOWN) begin
          $display("%0t: unexpected byte %h last %b count %0d", $realtime,
                   out_chan.out_byte, out_chan.out_last, out_chan.bytes_written);
        end
      end else begin
        want = pending_chars.pop_front();
        if (out_chan.out_byte !== want.ch || out_chan.out_last !== want.last ||
            out_chan.bytes_written !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_MISMATCH_SHOWN) begin
            $display("%0t: mismatch byte exp %h got %h, last exp %b got %b, count exp %0d got %0d",
                     $realtime, want.ch, out_chan.out_byte, want.last, out_chan.out_last,
                     want.count, out_chan.bytes_written);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // literal bytes at both ends of the range
  task automatic test_literals();
    send_request(8'h01, {$urandom, $urandom}, 1'b1);
    send_request(8'hff, '1, 1'b0);
  endtask

  // every conversion at its edge values
  task automatic test_conversions();
    send_conversion(CH_C, '1);
    send_conversion(CH_D, 64'hffff_ffff_8000_0000);  // most negative int
    send_conversion(CH_I, '1);                       // minus one
    send_conversion(CH_U, 64'h0000_0000_ffff_ffff);
    send_conversion(CH_XL, 64'hffff_ffff_0000_0000); // only low half counts: "0"
    send_conversion(CH_XU, 64'h1234_5678_9abc_def0);
    send_conversion(CH_P, 64'd0);                    // "(nil)"
    send_conversion(CH_P, '1);                       // longest result, 18 bytes
    send_conversion(CH_PCT, {$urandom, $urandom});
  endtask

  // unsupported string conversion, unknown letter, trailing percents
  task automatic test_special_cases();
    send_conversion(CH_S, {$urandom, $urandom});
    send_conversion(SEL_UNKNOWN, {$urandom, $urandom});
    // percent then end of string
    send_conversion(CH_NUL, {$urandom, $urandom});
    // percent then a fresh string: the new byte is a literal
    send_request(CH_PCT, {$urandom, $urandom}, 1'b0);
    send_request(CH_A_UP, {$urandom, $urandom}, 1'b1);
  endtask

  // random strings: mostly literals and well-formed conversions, some
  // unknown letters, string ends and trailing percents
  task automatic test_random_strings();
    int         sent;
    int         kind;
    logic       start;
    logic [7:0] sel;
    sent  = 0;
    start = 1'b1;
    while (sent < 330) begin
      // switch idling on and off now and then so some stretches run clean
      if ($urandom_range(0, 29) == 0) begin
        sender_idle   = ($urandom_range(0, 3) != 0);
        receiver_idle = ($urandom_range(0, 3) != 0);
      end
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        send_request(rand_literal(), {$urandom, $urandom}, start);
        sent++;
        start = 1'b0;
      end else if (kind < 18) begin
        if (kind == 17) begin
          sel = 8'($urandom_range(1, 255));
        end else begin
          sel = CONV_SEL[$urandom_range(0, 8)];
        end
        send_request(CH_PCT, rand_arg(), start);
        send_request(sel, rand_arg(), 1'b0);
        sent += 2;
        start = 1'b0;
      end else if (kind == 18) begin
        send_request(CH_NUL, rand_arg(), start);
        sent++;
        start = 1'b1;
      end else begin
        // percent left dangling; the next request opens a new string
        send_request(CH_PCT, rand_arg(), start);
        sent++;
        start = 1'b1;
      end
    end
  endtask

  // receiver holds off for a long stretch while full pointers keep coming,
  // so the output register fills and in_chan.ready drops
  task automatic test_output_backpressure();
    sender_idle = 1'b0;
    hold_left   = HOLD_OFF_CYCLES;
    repeat (12) begin
      send_conversion(CH_P, {1'b1, 63'($urandom) << 32} | 64'($urandom));
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_steady_stream();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    send_request(rand_literal(), rand_arg(), 1'b1);
    repeat (20) begin
      send_conversion(CONV_SEL[$urandom_range(0, 8)], rand_arg());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.fmt_byte     = '0;
    in_chan.arg_value    = '0;
    in_chan.string_start = 1'b0;
    out_chan.ready       = 1'b0;
    pct_held             = 1'b0;
    char_count           = '0;
    sender_idle          = 1'b1;
    receiver_idle        = 1'b1;
    hold_left            = 0;
    stall_left           = 0;
    mismatch_count       = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_literals();
    test_conversions();
    test_special_cases();
    test_random_strings();
    test_output_backpressure();
    test_steady_stream();

    // stop offering, wait for every owed byte, then let the block settle
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
